### rtl/dfe_pkg.sv
package dfe_pkg;

  localparam int WidthW   = 16;
  localparam int ValueW   = 11;
  localparam int CntW     = 5;
  localparam int CfgIdxW  = 3;
  localparam int CfgDataW = 16;

  // register indexes on the configuration port
  localparam logic [CfgIdxW-1:0] REG_PROSHOT_MODE = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_BIT_ONE      = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_BIT_ZERO     = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_NIB_BASE     = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_NIB_STEP     = 3'd4;

  // symbols per frame
  localparam logic [CntW-1:0] SYMS_DSHOT   = 5'd16;
  localparam logic [CntW-1:0] SYMS_PROSHOT = 5'd4;

  typedef struct packed {
    logic [ValueW-1:0] throttle_value;
    logic              telemetry_request;
  } dfe_in_t;

  typedef struct packed {
    logic [WidthW-1:0] symbol_width;
    logic              last_symbol;
  } dfe_out_t;

  typedef struct packed {
    logic        proshot_mode;
    logic [15:0] bit_one_width;
    logic [15:0] bit_zero_width;
    logic [14:0] nibble_base_width;
    logic [10:0] nibble_step_width;
  } dfe_cfg_t;

  // 12-bit word plus xor of its three nibbles
  function automatic logic [15:0] build_frame(dfe_in_t d);
    logic [11:0] word;
    logic [3:0]  csum;
    word = {d.throttle_value, d.telemetry_request};
    csum = word[3:0] ^ word[7:4] ^ word[11:8];
    return {word, csum};
  endfunction

endpackage

### rtl/dfe_cfg_regs.sv
module dfe_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          wr_en,
  input  logic [dfe_pkg::CfgIdxW-1:0]   wr_index,
  input  logic [dfe_pkg::CfgDataW-1:0]  wr_data,
  output dfe_pkg::dfe_cfg_t             cfg
);
  import dfe_pkg::*;

  dfe_cfg_t cfg_r;
  dfe_cfg_t cfg_nxt;

  // decode the write, indexes past the list are dropped
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (wr_index)
        REG_PROSHOT_MODE: cfg_nxt.proshot_mode      = wr_data[0];
        REG_BIT_ONE:      cfg_nxt.bit_one_width     = wr_data;
        REG_BIT_ZERO:     cfg_nxt.bit_zero_width    = wr_data;
        REG_NIB_BASE:     cfg_nxt.nibble_base_width = wr_data[14:0];
        REG_NIB_STEP:     cfg_nxt.nibble_step_width = wr_data[10:0];
        default:          cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### rtl/dshot_frame_encoder.sv
// channel | direction | handshake            | payload
// in      | input     | in_valid / in_ready   | in_data   (throttle_value, telemetry_request)
// out     | output    | out_valid / out_ready | out_data  (symbol_width, last_symbol)
// cfg     | input     | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// one symbol word per cycle leaves the symbol shifter while the output is not stalled:
// a frame is 16 symbols in DShot mode and 4 in ProShot mode.
// the first symbol passes the frame register, the symbol shifter, then the output
// register; the next input word is held in the frame register meanwhile.
// reset is synchronous, active low, and clears all control state and registers.
// a stalled output holds the shifter; cfg_ready is always high.
module dshot_frame_encoder (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  dfe_pkg::dfe_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output dfe_pkg::dfe_out_t             out_data,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dfe_pkg::CfgIdxW-1:0]   cfg_index,
  input  logic [dfe_pkg::CfgDataW-1:0]  cfg_data
);
  import dfe_pkg::*;

  dfe_cfg_t cfg;

  logic              pend_valid_r, pend_valid_nxt;
  logic [15:0]       pend_frame_r, pend_frame_nxt;
  logic [15:0]       shift_r, shift_nxt;
  logic [CntW-1:0]   left_r, left_nxt;
  logic              out_valid_r, out_valid_nxt;
  dfe_out_t          out_data_r, out_data_nxt;

  logic              in_acc;
  logic              gen_busy;
  logic              gen_adv;
  logic              gen_done;
  logic              load;
  logic [14:0]       nib_prod;
  logic [WidthW-1:0] sym_width;
  logic [15:0]       shift_adv;

  assign cfg_ready = 1'b1;

  dfe_cfg_regs u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_valid & cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // handshake and pipeline control
  assign in_ready = !pend_valid_r;
  assign in_acc   = in_valid & in_ready;
  assign gen_busy = (left_r != '0);
  assign gen_adv  = gen_busy & (!out_valid_r | out_ready);
  assign gen_done = !gen_busy | (gen_adv & (left_r == CntW'(1)));
  assign load     = pend_valid_r & gen_done;

  // symbol width for the current head of the shifter
  assign nib_prod  = 15'(shift_r[15:12]) * 15'(cfg.nibble_step_width);
  assign sym_width = cfg.proshot_mode
                   ? ({1'b0, cfg.nibble_base_width} + {1'b0, nib_prod})
                   : (shift_r[15] ? cfg.bit_one_width : cfg.bit_zero_width);
  assign shift_adv = cfg.proshot_mode ? {shift_r[11:0], 4'b0000}
                                      : {shift_r[14:0], 1'b0};

  // frame register
  always_comb begin
    pend_valid_nxt = pend_valid_r;
    pend_frame_nxt = pend_frame_r;
    if (in_acc) begin
      pend_valid_nxt = 1'b1;
      pend_frame_nxt = build_frame(in_data);
    end else if (load) begin
      pend_valid_nxt = 1'b0;
    end
  end

  // symbol shifter
  always_comb begin
    shift_nxt = shift_r;
    left_nxt  = left_r;
    if (load) begin
      shift_nxt = pend_frame_r;
      left_nxt  = cfg.proshot_mode ? SYMS_PROSHOT : SYMS_DSHOT;
    end else if (gen_adv) begin
      shift_nxt = shift_adv;
      left_nxt  = left_r - CntW'(1);
    end
  end

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    if (gen_adv) begin
      out_valid_nxt             = 1'b1;
      out_data_nxt.symbol_width = sym_width;
      out_data_nxt.last_symbol  = (left_r == CntW'(1));
    end else if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
      pend_frame_r <= '0;
      shift_r      <= '0;
      left_r       <= '0;
      out_valid_r  <= 1'b0;
      out_data_r   <= '0;
    end else begin
      pend_valid_r <= pend_valid_nxt;
      pend_frame_r <= pend_frame_nxt;
      shift_r      <= shift_nxt;
      left_r       <= left_nxt;
      out_valid_r  <= out_valid_nxt;
      out_data_r   <= out_data_nxt;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // count never exceeds a DShot frame
  a_left_range: assert property (@(posedge clk) disable iff (!rst_n)
    left_r <= SYMS_DSHOT)
    else $error("symbol count out of range");

  // a loaded frame starts with a full symbol count
  a_load_count: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> (left_r == SYMS_DSHOT || left_r == SYMS_PROSHOT))
    else $error("bad symbol count after load");

  // final symbol of a frame is marked
  a_last_mark: assert property (@(posedge clk) disable iff (!rst_n)
    (gen_adv && left_r == CntW'(1)) |=> (out_valid_r && out_data_r.last_symbol))
    else $error("last symbol not marked");

  // an accepted word is held until the shifter takes it
  a_pend_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (pend_valid_r && !load) |=> (pend_valid_r && $stable(pend_frame_r)))
    else $error("pending frame lost");

endmodule

### tb/dshot_frame_encoder_test.sv
`timescale 1ns / 100ps

module dshot_frame_encoder_test;
  import dfe_pkg::*;

  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned SettleCycles = 6;
  localparam int unsigned LastIndex    = (1 << CfgIdxW) - 1;

  logic                clk       = 1'b0;
  logic                rst_n     = 1'b0;
  logic                in_valid  = 1'b0;
  logic                in_ready;
  dfe_in_t             in_data   = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  dfe_out_t            out_data;
  logic                cfg_valid = 1'b0;
  logic                cfg_ready;
  logic [CfgIdxW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0] cfg_data  = '0;

  // shadow of the encoder registers, as last written
  dfe_cfg_t    cfg_shadow = '0;
  // words waiting to be sent, and symbols still owed by the encoder
  dfe_in_t     throttle_words[$];
  dfe_out_t    expected_symbols[$];
  int unsigned words_in_flight = 0;
  int unsigned in_gap          = 0;
  int unsigned out_stall       = 0;
  int unsigned idle_cycles     = 0;
  int unsigned errors          = 0;
  bit          quiet           = 1'b0;

  dshot_frame_encoder dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // mostly short gaps, now and then a long one
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (quiet || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(6, 30);
  endfunction

  // frame = {value, telemetry, xor of the three word nibbles}, shifted out msb first
  function automatic void encode_frame(dfe_in_t w);
    logic [15:0]       frame;
    logic [3:0]        check;
    logic [WidthW-1:0] width;
    dfe_out_t          sym;
    int                count;
    int                k;
    frame = {w.throttle_value, w.telemetry_request, 4'b0000};
    check = frame[15:12] ^ frame[11:8] ^ frame[7:4];
    frame[3:0] = check;
    count = cfg_shadow.proshot_mode ? 4 : 16;
    for (k = 0; k < count; k++) begin
      if (cfg_shadow.proshot_mode) begin
        width = {1'b0, cfg_shadow.nibble_base_width}
              + {12'b0, frame[15:12]} * {5'b0, cfg_shadow.nibble_step_width};
        frame = frame << 4;
      end else begin
        width = frame[15] ? cfg_shadow.bit_one_width : cfg_shadow.bit_zero_width;
        frame = frame << 1;
      end
      sym.symbol_width = width;
      sym.last_symbol  = (k == count - 1);
      expected_symbols.push_back(sym);
    end
  endfunction

  // input driver: hold the word until taken, then gap, then the next word
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap = 0;
    end else begin
      if (in_valid && in_ready) begin
        encode_frame(in_data);
        words_in_flight--;
      end
      if (!(in_valid && !in_ready)) begin
        if (in_gap > 0) begin
          in_gap--;
          in_valid <= 1'b0;
        end else if (throttle_words.size() > 0) begin
          in_data  <= throttle_words.pop_front();
          in_valid <= 1'b1;
          in_gap = pick_gap();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // output back-pressure
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_stall = 0;
    end else if (out_stall > 0) begin
      out_stall--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
      out_stall = pick_gap();
    end
  end

  // result monitor
  always @(posedge clk) begin
    dfe_out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (expected_symbols.size() == 0) begin
        $display("%0t: unexpected symbol width %0d last %0b", $time,
                 out_data.symbol_width, out_data.last_symbol);
        errors++;
      end else begin
        want = expected_symbols.pop_front();
        if (out_data.symbol_width !== want.symbol_width) begin
          $display("%0t: symbol_width expected %0d got %0d", $time,
                   want.symbol_width, out_data.symbol_width);
          errors++;
        end
        if (out_data.last_symbol !== want.last_symbol) begin
          $display("%0t: last_symbol expected %0b got %0b", $time,
                   want.last_symbol, out_data.last_symbol);
          errors++;
        end
      end
    end
  end

  // register shadow follows accepted writes
  always @(posedge clk) begin
    if (rst_n && cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_PROSHOT_MODE: cfg_shadow.proshot_mode      = cfg_data[0];
        REG_BIT_ONE:      cfg_shadow.bit_one_width     = cfg_data;
        REG_BIT_ZERO:     cfg_shadow.bit_zero_width    = cfg_data;
        REG_NIB_BASE:     cfg_shadow.nibble_base_width = cfg_data[14:0];
        REG_NIB_STEP:     cfg_shadow.nibble_step_width = cfg_data[10:0];
        default: ;
      endcase
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (!rst_n || (in_valid && in_ready) || (out_valid && out_ready) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
    end
    if (idle_cycles >= StallLimit) begin
      $display("end of test: mismatches");
      $finish;
    end
  end

  // present one register write and wait until it is taken; valid stays high
  task automatic cfg_put(input logic [CfgIdxW-1:0] idx, input logic [CfgDataW-1:0] value);
    cfg_index <= idx;
    cfg_data  <= value;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
  endtask

  // write every register, unused upper bits filled with noise, then a stray index
  task automatic program_regs(input dfe_cfg_t s);
    cfg_put(REG_PROSHOT_MODE, {15'($urandom), s.proshot_mode});
    cfg_put(REG_BIT_ONE, s.bit_one_width);
    cfg_put(REG_BIT_ZERO, s.bit_zero_width);
    cfg_put(REG_NIB_BASE, {1'($urandom), s.nibble_base_width});
    cfg_put(REG_NIB_STEP, {5'($urandom), s.nibble_step_width});
    cfg_put(CfgIdxW'($urandom_range(int'(REG_NIB_STEP) + 1, LastIndex)),
            CfgDataW'($urandom));
    cfg_valid <= 1'b0;
  endtask

  task automatic send_word(input logic [ValueW-1:0] value, input logic tlm);
    dfe_in_t w;
    w.throttle_value    = value;
    w.telemetry_request = tlm;
    words_in_flight++;
    throttle_words.push_back(w);
  endtask

  // wait for every word taken and every symbol seen, then let the pipeline settle
  task automatic drain();
    do @(posedge clk); while (words_in_flight != 0 || expected_symbols.size() != 0);
    repeat (SettleCycles) @(posedge clk);
  endtask

  function automatic logic [15:0] pick_width(input logic [15:0] max_val);
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 20) return '0;
    if (r < 40) return max_val;
    return 16'($urandom_range(0, max_val));
  endfunction

  initial begin
    dfe_cfg_t    s;
    int unsigned p;
    int unsigned n;
    int unsigned r;
    logic [ValueW-1:0] v;

    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // registers still at reset: dshot with zero widths
    send_word(11'd0, 1'b1);
    send_word(11'd2047, 1'b0);
    drain();

    // dshot, full-scale one width against zero
    s = '0;
    s.bit_one_width = 16'hffff;
    program_regs(s);
    send_word(11'd0, 1'b0);
    send_word(11'd0, 1'b1);
    send_word(11'd2047, 1'b0);
    send_word(11'd2047, 1'b1);
    send_word(11'h555, 1'b0);
    send_word(11'h2aa, 1'b1);
    drain();

    // dshot, widths swapped
    s.bit_one_width  = 16'h0000;
    s.bit_zero_width = 16'hffff;
    program_regs(s);
    send_word(11'h555, 1'b1);
    send_word(11'h0f0, 1'b0);
    drain();

    // proshot at largest base and step, all-ones frame gives the widest symbol
    s = '0;
    s.proshot_mode      = 1'b1;
    s.nibble_base_width = 15'h7fff;
    s.nibble_step_width = 11'h7ff;
    program_regs(s);
    send_word(11'd0, 1'b0);
    send_word(11'd0, 1'b1);
    send_word(11'd2047, 1'b0);
    send_word(11'd2047, 1'b1);
    send_word(11'h555, 1'b0);
    send_word(11'h2aa, 1'b1);
    drain();

    // proshot with zero base and step
    s.nibble_base_width = '0;
    s.nibble_step_width = '0;
    program_regs(s);
    send_word(11'h3c5, 1'b1);
    drain();

    // random phases, alternating modes, two of them with no idling
    for (p = 0; p < 8; p++) begin
      s.proshot_mode      = p[0];
      s.bit_one_width     = pick_width(16'hffff);
      s.bit_zero_width    = pick_width(16'hffff);
      s.nibble_base_width = 15'(pick_width(16'h7fff));
      s.nibble_step_width = 11'(pick_width(16'h07ff));
      program_regs(s);
      quiet = (p == 3 || p == 6);
      for (n = 0; n < 32; n++) begin
        r = $urandom_range(0, 99);
        if (r < 5) v = '0;
        else if (r < 10) v = '1;
        else v = ValueW'($urandom);
        send_word(v, 1'($urandom));
      end
      drain();
      quiet = 1'b0;
    end

    repeat (20) @(posedge clk);
    if (errors == 0 && expected_symbols.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
